### hw/rtl/srh_pkg.sv
// Shared types, codes and constants for the source routing header step block.
`timescale 1ns / 1ps

package srh_pkg;

   // Result action codes
   typedef enum logic [1:0] {
      ACT_CONTINUE = 2'd0,
      ACT_FORWARD  = 2'd1,
      ACT_DROP     = 2'd2
   } action_type;

   localparam logic [7:0] NO_NEXT_HEADER = 8'd59;
   localparam logic [4:0] ADDR_OCTETS    = 5'd16;
   localparam logic [15:0] RTYPE_PTR_BACK = 16'd6;
   localparam logic [15:0] SLEFT_PTR_BACK = 16'd5;
   localparam logic [15:0] NXT_PTR_BACK   = 16'd8;
   localparam logic [7:0] RTYPE_RESET    = 8'd3;

   // Request beat, last field in the lowest bits (79 bits)
   typedef struct packed {
      logic [15:0] bytes_remaining;
      logic [15:0] header_offset;
      logic [3:0]  pad_len;
      logic [3:0]  cmpr_e;
      logic [3:0]  cmpr_i;
      logic [7:0]  segments_left;
      logic [7:0]  routing_type;
      logic [7:0]  hdr_ext_len;
      logic [7:0]  next_header;
      logic        dst_is_multicast;
      logic        icmp_disabled;
      logic        node_is_destination;
   } req_type;

   // Response beat, last field in the lowest bits (88 bits)
   typedef struct packed {
      logic [15:0] next_offset;
      logic [3:0]  elide_count;
      logic [4:0]  read_length;
      logic [11:0] segment_offset;
      logic [7:0]  segments_left_out;
      logic [15:0] next_hdr_field_pointer;
      logic [7:0]  next_header_out;
      logic [15:0] error_pointer;
      logic        icmp_emit;
      action_type  action;
   } rsp_type;

   // Per-item context carried down the pipeline
   typedef struct packed {
      logic        is_dst;
      logic        quiet;
      logic        dst_mc;
      logic        rtype_ok;
      logic [7:0]  nxt;
      logic [7:0]  sleft;
      logic [3:0]  ci;
      logic [3:0]  ce;
      logic [4:0]  div;
      logic [10:0] hlen;
      logic [15:0] off;
      logic [15:0] rem;
   } ctx_type;

   // floor(65536 / d) + 1: exact floor(n / d) for n < 2048 via (n * m) >> 16
   function automatic logic [16:0] recip(input logic [4:0] d);
      logic [16:0] m;
      case (d)
         5'd1:    m = 17'd65537;
         5'd2:    m = 17'd32769;
         5'd3:    m = 17'd21846;
         5'd4:    m = 17'd16385;
         5'd5:    m = 17'd13108;
         5'd6:    m = 17'd10923;
         5'd7:    m = 17'd9363;
         5'd8:    m = 17'd8193;
         5'd9:    m = 17'd7282;
         5'd10:   m = 17'd6554;
         5'd11:   m = 17'd5958;
         5'd12:   m = 17'd5462;
         5'd13:   m = 17'd5042;
         5'd14:   m = 17'd4682;
         5'd15:   m = 17'd4370;
         5'd16:   m = 17'd4097;
         default: m = 17'd0;
      endcase
      return m;
   endfunction

endpackage

### hw/rtl/srh_decode.sv
// Stage 1: field decode, length, tail underflow, divisor and reciprocal lookup.
`timescale 1ns / 1ps

module srh_decode (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  srh_pkg::req_type in_req,
   input  logic [7:0]      rtype_cfg,
   output logic            s1_valid,
   output srh_pkg::ctx_type s1_ctx,
   output logic            s1_under,
   output logic [10:0]     s1_num,
   output logic [16:0]     s1_recip
);
   import srh_pkg::*;

   logic        valid_ff;
   ctx_type     ctx_ff, ctx_in;
   logic        under_ff, under_in;
   logic [10:0] num_ff, num_in;
   logic [16:0] recip_ff, recip_in;
   logic [5:0]  tail;

   // decode and tail arithmetic
   always_comb begin
      ctx_in.is_dst   = in_req.node_is_destination;
      ctx_in.quiet    = in_req.icmp_disabled;
      ctx_in.dst_mc   = in_req.dst_is_multicast;
      ctx_in.rtype_ok = (in_req.routing_type == rtype_cfg);
      ctx_in.nxt      = in_req.next_header;
      ctx_in.sleft    = in_req.segments_left;
      ctx_in.ci       = in_req.cmpr_i;
      ctx_in.ce       = in_req.cmpr_e;
      ctx_in.div      = ADDR_OCTETS - {1'b0, in_req.cmpr_i};
      ctx_in.hlen     = {in_req.hdr_ext_len, 3'b000};
      ctx_in.off      = in_req.header_offset;
      ctx_in.rem      = in_req.bytes_remaining;
      tail     = {2'b00, in_req.pad_len} + {1'b0, ADDR_OCTETS} - {2'b00, in_req.cmpr_e};
      under_in = ctx_in.hlen < {5'd0, tail};
      num_in   = ctx_in.hlen - {5'd0, tail};
      recip_in = recip(ctx_in.div);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_ff   <= ctx_in;
         under_ff <= under_in;
         num_ff   <= num_in;
         recip_ff <= recip_in;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_ctx   = ctx_ff;
   assign s1_under = under_ff;
   assign s1_num   = num_ff;
   assign s1_recip = recip_ff;

endmodule

### hw/rtl/srh_divide.sv
// Stages 2 and 3: reciprocal multiply, then segment count, count check and index.
`timescale 1ns / 1ps

module srh_divide (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             s1_valid,
   input  srh_pkg::ctx_type s1_ctx,
   input  logic             s1_under,
   input  logic [10:0]      s1_num,
   input  logic [16:0]      s1_recip,
   output logic             s3_valid,
   output srh_pkg::ctx_type s3_ctx,
   output logic             s3_count_ok,
   output logic [11:0]      s3_index,
   output logic [3:0]       s3_elide,
   output logic [4:0]       s3_rd
);
   import srh_pkg::*;

   // stage 2 registers
   logic        v2_ff;
   ctx_type     ctx2_ff;
   logic        under2_ff;
   logic [27:0] prod_ff, prod_in;

   // stage 3 registers
   logic        v3_ff;
   ctx_type     ctx3_ff;
   logic        ok_ff, ok_in;
   logic [11:0] index_ff, index_in;
   logic [3:0]  elide_ff, elide_in;
   logic [4:0]  rd_ff, rd_in;
   logic [11:0] count;

   assign prod_in = {17'd0, s1_num} * {11'd0, s1_recip};

   // count = quotient + 1, zero on underflow; last segment uses cmpr_e
   always_comb begin
      count    = under2_ff ? 12'd0 : ({1'b0, prod_ff[26:16]} + 12'd1);
      ok_in    = {4'd0, ctx2_ff.sleft} <= count;
      index_in = count - {4'd0, ctx2_ff.sleft};
      elide_in = (ctx2_ff.sleft == 8'd1) ? ctx2_ff.ce : ctx2_ff.ci;
      rd_in    = ADDR_OCTETS - {1'b0, elide_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= s1_valid;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx2_ff   <= s1_ctx;
         under2_ff <= s1_under;
         prod_ff   <= prod_in;
         ctx3_ff   <= ctx2_ff;
         ok_ff     <= ok_in;
         index_ff  <= index_in;
         elide_ff  <= elide_in;
         rd_ff     <= rd_in;
      end
   end

   assign s3_valid    = v3_ff;
   assign s3_ctx      = ctx3_ff;
   assign s3_count_ok = ok_ff;
   assign s3_index    = index_ff;
   assign s3_elide    = elide_ff;
   assign s3_rd       = rd_ff;

endmodule

### hw/rtl/srh_locate.sv
// Stage 4: address offset multiply, then the forward / continue / drop decision.
`timescale 1ns / 1ps

module srh_locate (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             s3_valid,
   input  srh_pkg::ctx_type s3_ctx,
   input  logic             s3_count_ok,
   input  logic [11:0]      s3_index,
   input  logic [3:0]       s3_elide,
   input  logic [4:0]       s3_rd,
   output logic             res_valid,
   output srh_pkg::rsp_type res
);
   import srh_pkg::*;

   logic        v4_ff;
   ctx_type     ctx4_ff;
   logic        ok4_ff;
   logic [3:0]  elide4_ff;
   logic [4:0]  rd4_ff;
   logic [16:0] seg_ff, seg_in;
   logic        seg_bad;
   logic        len_bad;

   assign seg_in = {5'd0, s3_index} * {12'd0, s3_ctx.div};

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= s3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx4_ff   <= s3_ctx;
         ok4_ff    <= s3_count_ok;
         elide4_ff <= s3_elide;
         rd4_ff    <= s3_rd;
         seg_ff    <= seg_in;
      end
   end

   // range checks against header length and available bytes
   assign seg_bad = (seg_ff + {12'd0, rd4_ff}) > {6'd0, ctx4_ff.hlen};
   assign len_bad = {5'd0, ctx4_ff.hlen} > ctx4_ff.rem;

   // decision
   always_comb begin
      res                        = '0;
      res.next_header_out        = NO_NEXT_HEADER;
      res.action                 = ACT_DROP;
      if (!ctx4_ff.is_dst) begin
         res.action = ACT_FORWARD;
      end else if (ctx4_ff.sleft == 8'd0) begin
         if (!len_bad) begin
            res.action                 = ACT_CONTINUE;
            res.next_header_out        = ctx4_ff.nxt;
            res.next_hdr_field_pointer = ctx4_ff.off - NXT_PTR_BACK;
            res.next_offset            = ctx4_ff.off + {5'd0, ctx4_ff.hlen};
         end
      end else if (!ctx4_ff.rtype_ok) begin
         if (!ctx4_ff.quiet) begin
            res.icmp_emit     = 1'b1;
            res.error_pointer = ctx4_ff.off - RTYPE_PTR_BACK;
         end
      end else if (!ok4_ff) begin
         if (!ctx4_ff.quiet) begin
            res.icmp_emit     = 1'b1;
            res.error_pointer = ctx4_ff.off - SLEFT_PTR_BACK;
         end
      end else begin
         res.segments_left_out = ctx4_ff.sleft - 8'd1;
         if (!ctx4_ff.dst_mc && !seg_bad && !len_bad) begin
            res.action         = ACT_FORWARD;
            res.segment_offset = seg_ff[11:0];
            res.read_length    = rd4_ff;
            res.elide_count    = elide4_ff;
            res.next_offset    = ctx4_ff.off + {5'd0, ctx4_ff.hlen};
         end
      end
   end

   assign res_valid = v4_ff;

endmodule

### hw/rtl/srh_skid.sv
// Output register with one skid entry; stalls the pipeline only when the skid is full.
`timescale 1ns / 1ps

module srh_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  srh_pkg::rsp_type in_data,
   output logic             full,
   output logic             out_valid,
   input  logic             out_ready,
   output srh_pkg::rsp_type out_data
);
   import srh_pkg::*;

   logic    out_v_ff, out_v_in;
   logic    skid_v_ff, skid_v_in;
   rsp_type out_d_ff, out_d_in;
   rsp_type skid_d_ff, skid_d_in;
   logic    out_free;

   assign out_free = !out_v_ff || out_ready;

   // steer the incoming beat to the output register or the skid entry
   always_comb begin
      out_v_in  = out_v_ff;
      skid_v_in = skid_v_ff;
      out_d_in  = out_d_ff;
      skid_d_in = skid_d_ff;
      if (skid_v_ff) begin
         if (out_free) begin
            out_v_in  = 1'b1;
            out_d_in  = skid_d_ff;
            skid_v_in = 1'b0;
         end
      end else if (en && in_valid) begin
         if (out_free) begin
            out_v_in = 1'b1;
            out_d_in = in_data;
         end else begin
            skid_v_in = 1'b1;
            skid_d_in = in_data;
         end
      end else if (out_free) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_d_ff  <= out_d_in;
      skid_d_ff <= skid_d_in;
   end

   assign full      = skid_v_ff;
   assign out_valid = out_v_ff;
   assign out_data  = out_d_ff;

endmodule

### hw/rtl/source_route_header_step_top.sv
// Throughput: one header per cycle while the skid entry is empty. A request passes
// the stages decode, reciprocal multiply, count check, address offset multiply with
// decision, and the output register, in that order, before it shows on rsp_tvalid.
// req_tready drops only while the output skid entry holds a beat.
// Reset (synchronous, active high) empties all stages and sets the routing type to 3.
`timescale 1ns / 1ps

module source_route_header_step_top (
   input  logic        clock,
   input  logic        reset,
   // request: node_is_destination, icmp_disabled, dst_is_multicast, next_header,
   // hdr_ext_len, routing_type, segments_left, cmpr_i, cmpr_e, pad_len,
   // header_offset, bytes_remaining, zero fill
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,
   // response: action, icmp_emit, error_pointer, next_header_out,
   // next_hdr_field_pointer, segments_left_out, segment_offset, read_length,
   // elide_count, next_offset
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,
   // supported_routing_type write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);
   import srh_pkg::*;

   logic [7:0] rtype_cfg_ff;
   logic    en;
   logic    skid_full;
   req_type req;
   logic    s1_valid, s3_valid, res_valid;
   ctx_type s1_ctx, s3_ctx;
   logic    s1_under, s3_count_ok;
   logic [10:0] s1_num;
   logic [16:0] s1_recip;
   logic [11:0] s3_index;
   logic [3:0]  s3_elide;
   logic [4:0]  s3_rd;
   rsp_type res, rsp;

   // configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         rtype_cfg_ff <= RTYPE_RESET;
      end else if (csr_valid) begin
         rtype_cfg_ff <= csr_data;
      end
   end

   // whole pipeline advances unless the skid entry is occupied
   assign en         = !skid_full;
   assign req_tready = en;
   assign req        = req_type'(req_tdata[78:0]);

   srh_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid && req_tready),
      .in_req    (req),
      .rtype_cfg (rtype_cfg_ff),
      .s1_valid  (s1_valid),
      .s1_ctx    (s1_ctx),
      .s1_under  (s1_under),
      .s1_num    (s1_num),
      .s1_recip  (s1_recip)
   );

   srh_divide u_divide (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .s1_valid    (s1_valid),
      .s1_ctx      (s1_ctx),
      .s1_under    (s1_under),
      .s1_num      (s1_num),
      .s1_recip    (s1_recip),
      .s3_valid    (s3_valid),
      .s3_ctx      (s3_ctx),
      .s3_count_ok (s3_count_ok),
      .s3_index    (s3_index),
      .s3_elide    (s3_elide),
      .s3_rd       (s3_rd)
   );

   srh_locate u_locate (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .s3_valid    (s3_valid),
      .s3_ctx      (s3_ctx),
      .s3_count_ok (s3_count_ok),
      .s3_index    (s3_index),
      .s3_elide    (s3_elide),
      .s3_rd       (s3_rd),
      .res_valid   (res_valid),
      .res         (res)
   );

   srh_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (res_valid),
      .in_data   (res),
      .full      (skid_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   assign rsp_tdata = rsp;

endmodule

### hw/rtl/srh_checker.sv
// Port-level checks on the response stream, bound to the top level.
`timescale 1ns / 1ps

module srh_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata
);
   import srh_pkg::*;

   // a stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response beat changed");

   // a parameter problem message only comes with a drop
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[1:0] == ACT_DROP)
      else $error("icmp_emit without drop");

   // only continue carries the header's own next header and its pointer
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != ACT_CONTINUE
      |-> rsp_tdata[26:19] == NO_NEXT_HEADER && rsp_tdata[42:27] == 16'd0)
      else $error("next header fields set outside continue");

   // address fields only on a forward
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != ACT_FORWARD |-> rsp_tdata[71:51] == 21'd0)
      else $error("address fields set outside forward");

   // no response right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind source_route_header_step_top srh_checker u_srh_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### test/srh_step_checker.sv
// Checker for the source routing header step: predicts each result beat and compares it.
`timescale 1ns / 1ps

module srh_step_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // request: node_is_destination, icmp_disabled, dst_is_multicast, next_header,
   // hdr_ext_len, routing_type, segments_left, cmpr_i, cmpr_e, pad_len,
   // header_offset, bytes_remaining, zero fill
   input  logic [79:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // response: action, icmp_emit, error_pointer, next_header_out,
   // next_hdr_field_pointer, segments_left_out, segment_offset, read_length,
   // elide_count, next_offset
   input  logic [87:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_data,
   output int          mismatch_count,
   output int          pending_steps
);
   import srh_pkg::*;

   logic [7:0] routing_type_reg = RTYPE_RESET;
   rsp_type    expected_steps[$];

   // Decision and next-address lookup for one decoded header
   function automatic rsp_type predict_route_step(input req_type h, input logic [7:0] rtype_cfg);
      rsp_type     r;
      int unsigned hlen, tail, div, count, idx, seg_off, elide, rd;
      r = '0;
      r.next_header_out = NO_NEXT_HEADER;
      hlen = h.hdr_ext_len;
      hlen = hlen * 8;

      // not for us: pass it on untouched
      if (!h.node_is_destination) begin
         r.action = ACT_FORWARD;
         return r;
      end

      // no segments left: skip the header
      if (h.segments_left == 8'd0) begin
         if (hlen > h.bytes_remaining) begin
            r.action = ACT_DROP;
            return r;
         end
         r.action = ACT_CONTINUE;
         r.next_header_out = h.next_header;
         r.next_hdr_field_pointer = h.header_offset - NXT_PTR_BACK;
         r.next_offset = h.header_offset + hlen[15:0];
         return r;
      end

      if (h.routing_type != rtype_cfg) begin
         r.action = ACT_DROP;
         if (!h.icmp_disabled) begin
            r.icmp_emit = 1'b1;
            r.error_pointer = h.header_offset - RTYPE_PTR_BACK;
         end
         return r;
      end

      // segment count, zero when the header cannot hold the last address
      tail = h.pad_len;
      tail = tail + ADDR_OCTETS - h.cmpr_e;
      div = ADDR_OCTETS - h.cmpr_i;
      if (hlen < tail)
         count = 0;
      else
         count = (hlen - tail) / div + 1;

      if (h.segments_left > count) begin
         r.action = ACT_DROP;
         if (!h.icmp_disabled) begin
            r.icmp_emit = 1'b1;
            r.error_pointer = h.header_offset - SLEFT_PTR_BACK;
         end
         return r;
      end

      r.segments_left_out = h.segments_left - 8'd1;
      if (h.dst_is_multicast) begin
         r.action = ACT_DROP;
         return r;
      end

      // locate the next address; the last one uses the last-address elision
      idx = count - h.segments_left;
      seg_off = idx * div;
      elide = (idx == count - 1) ? h.cmpr_e : h.cmpr_i;
      rd = ADDR_OCTETS - elide;
      if (seg_off + rd > hlen || hlen > h.bytes_remaining) begin
         r.action = ACT_DROP;
         return r;
      end

      r.action = ACT_FORWARD;
      r.segment_offset = seg_off[11:0];
      r.read_length = rd[4:0];
      r.elide_count = elide[3:0];
      r.next_offset = h.header_offset + hlen[15:0];
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want_v,
                              input logic [15:0] seen_v);
      if (want_v !== seen_v) begin
         $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want_v, seen_v);
         mismatch_count++;
      end
   endtask

   // Track register writes, queue predictions, compare result beats
   always @(posedge clock) begin : watch
      req_type hdr;
      rsp_type seen, want;
      if (reset) begin
         routing_type_reg = RTYPE_RESET;
         expected_steps.delete();
         mismatch_count = 0;
      end else begin
         if (csr_valid && csr_ready)
            routing_type_reg = csr_data;
         if (req_tvalid && req_tready) begin
            hdr = req_tdata[78:0];
            expected_steps.push_back(predict_route_step(hdr, routing_type_reg));
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (expected_steps.size() == 0) begin
               $display("%0t: result beat with nothing expected, actual 0x%0h", $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_steps.pop_front();
               check_field("action", want.action, seen.action);
               check_field("icmp_emit", want.icmp_emit, seen.icmp_emit);
               check_field("error_pointer", want.error_pointer, seen.error_pointer);
               check_field("next_header_out", want.next_header_out, seen.next_header_out);
               check_field("next_hdr_field_pointer", want.next_hdr_field_pointer,
                           seen.next_hdr_field_pointer);
               check_field("segments_left_out", want.segments_left_out, seen.segments_left_out);
               check_field("segment_offset", want.segment_offset, seen.segment_offset);
               check_field("read_length", want.read_length, seen.read_length);
               check_field("elide_count", want.elide_count, seen.elide_count);
               check_field("next_offset", want.next_offset, seen.next_offset);
            end
         end
      end
      pending_steps = expected_steps.size();
   end

endmodule

### test/tb.sv
// Testbench top: drives headers and routing type writes into the block and gives the verdict.
`timescale 1ns / 1ps

module tb;
   import srh_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int STALL_LIMIT  = 1000;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 155;
   localparam int DRAIN_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = '0;

   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          quiet_cycles = 0;
   int          mismatch_count;
   int          pending_steps;
   logic [7:0]  routing_type_now = RTYPE_RESET;
   logic [7:0]  rtype_plan [PHASES] = '{8'h00, 8'hFF, 8'h03, 8'hA5, 8'h5A, 8'h80, 8'h01, 8'h7F};

   always #(HALF_PERIOD) clock = ~clock;

   source_route_header_step_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   srh_step_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_steps  (pending_steps)
   );

   // Receiver back-pressure
   always @(negedge clock)
      rsp_tready = ($urandom_range(99) >= recv_stall_pct);

   // Watchdog: too long with no beat on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Header that forwards: 32-byte header, four addresses, second-to-last chosen
   function automatic req_type forward_base();
      req_type h;
      h = '0;
      h.node_is_destination = 1'b1;
      h.next_header = 8'd17;
      h.hdr_ext_len = 8'd4;
      h.routing_type = RTYPE_RESET;
      h.segments_left = 8'd2;
      h.cmpr_i = 4'd8;
      h.cmpr_e = 4'd8;
      h.header_offset = 16'd40;
      h.bytes_remaining = 16'd100;
      return h;
   endfunction

   // Random header; a shaped one is addressed to us, mostly with a sane segment count
   function automatic req_type random_header(input logic [7:0] rtype, input bit shaped);
      req_type     h;
      logic [95:0] bits;
      int unsigned hlen, tail, div, count;
      bits = {$urandom, $urandom, $urandom};
      h = bits[78:0];
      if (shaped) begin
         h.node_is_destination = 1'b1;
         h.routing_type = rtype;
         h.dst_is_multicast = ($urandom_range(15) == 0);
         // mostly short headers, a few up to the largest
         h.hdr_ext_len = 8'(($urandom_range(9) == 0) ? $urandom_range(255)
                                                      : $urandom_range(12, 1));
         hlen = h.hdr_ext_len;
         hlen = hlen * 8;
         tail = h.pad_len;
         tail = tail + 16 - h.cmpr_e;
         div = 16 - h.cmpr_i;
         count = (hlen < tail) ? 0 : (hlen - tail) / div + 1;
         if ($urandom_range(7) == 0)
            h.segments_left = 8'd0;
         else if (count == 0)
            h.segments_left = 8'($urandom_range(3, 1));
         else if (count < 255 && $urandom_range(9) == 0)
            h.segments_left = 8'(count + 1);
         else
            h.segments_left = 8'($urandom_range((count > 255) ? 255 : count, 1));
         // usually the packet holds the whole header
         if (hlen > 0 && $urandom_range(7) == 0)
            h.bytes_remaining = 16'($urandom_range(hlen - 1, 0));
         else
            h.bytes_remaining = 16'($urandom_range(65535, hlen));
      end
      return h;
   endfunction

   // One request beat; valid stays up when the next beat follows directly
   task automatic send_header(input req_type h);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {1'b0, h};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Wait for all results, then let the pipeline empty
   task automatic settle();
      req_tvalid = 1'b0;
      while (pending_steps != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_routing_type(input logic [7:0] value);
      csr_valid = 1'b1;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
      routing_type_now = value;
   endtask

   initial begin
      req_type hdr;
      int      mode;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed headers, reset routing type
      send_header(forward_base());
      hdr = '1;
      hdr.node_is_destination = 1'b0;
      send_header(hdr);
      // no segments left: continue, pointer and offset wrap
      hdr = forward_base();
      hdr.segments_left = 8'd0;
      hdr.hdr_ext_len = 8'hFF;
      hdr.header_offset = 16'd0;
      hdr.bytes_remaining = 16'hFFFF;
      hdr.next_header = 8'hFF;
      send_header(hdr);
      hdr.header_offset = 16'hFFFF;
      hdr.next_header = 8'h00;
      send_header(hdr);
      // header longer than the packet
      hdr.bytes_remaining = 16'd2039;
      send_header(hdr);
      // wrong routing type, with and without a message
      hdr = forward_base();
      hdr.routing_type = 8'd4;
      hdr.header_offset = 16'd3;
      send_header(hdr);
      hdr.icmp_disabled = 1'b1;
      send_header(hdr);
      // count underflow
      hdr = forward_base();
      hdr.hdr_ext_len = 8'd0;
      hdr.segments_left = 8'd1;
      send_header(hdr);
      hdr.icmp_disabled = 1'b1;
      send_header(hdr);
      // segments left above the count
      hdr = forward_base();
      hdr.segments_left = 8'd5;
      hdr.header_offset = 16'd4;
      send_header(hdr);
      hdr.segments_left = 8'hFF;
      hdr.header_offset = 16'd5;
      send_header(hdr);
      // first address
      hdr = forward_base();
      hdr.segments_left = 8'd4;
      send_header(hdr);
      // last segment uses the last-address elision
      hdr = forward_base();
      hdr.segments_left = 8'd1;
      hdr.cmpr_e = 4'd2;
      send_header(hdr);
      // multicast destination
      hdr = forward_base();
      hdr.dst_is_multicast = 1'b1;
      send_header(hdr);
      // address area beyond the packet
      hdr = forward_base();
      hdr.bytes_remaining = 16'd31;
      send_header(hdr);
      // count wider than eight bits, then a header that holds just one address
      hdr = forward_base();
      hdr.cmpr_i = 4'd15;
      hdr.cmpr_e = 4'd0;
      hdr.pad_len = 4'd15;
      hdr.hdr_ext_len = 8'hFF;
      hdr.segments_left = 8'hFF;
      hdr.bytes_remaining = 16'hFFFF;
      hdr.header_offset = 16'hFFF0;
      send_header(hdr);
      hdr = forward_base();
      hdr.cmpr_i = 4'd0;
      hdr.cmpr_e = 4'd15;
      hdr.pad_len = 4'd15;
      hdr.hdr_ext_len = 8'd2;
      hdr.segments_left = 8'd1;
      send_header(hdr);
      // remaining fields at their top, routed to the last address
      hdr = '1;
      hdr.routing_type = RTYPE_RESET;
      hdr.segments_left = 8'd1;
      hdr.dst_is_multicast = 1'b0;
      send_header(hdr);

      // random phases, each with its own routing type and idling mode
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         write_routing_type(rtype_plan[phase]);
         mode = phase % 4;
         send_idle_pct = (mode == 1) ? 67 : (mode == 3) ? 12 : 0;
         recv_stall_pct = (mode == 2) ? 67 : (mode == 3) ? 12 : 0;
         for (int k = 0; k < PHASE_ITEMS; k++)
            send_header(random_header(routing_type_now, $urandom_range(3) != 0));
      end

      settle();
      if (mismatch_count == 0 && pending_steps == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
